// ----- hw/rtl/gpe_pkg.sv -----
// Shared types and constants of the glyph row pixel expander.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gpe_pkg;

    localparam int ROW_BITS_W = 24;
    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 16;
    localparam int GWIDTH_W   = 5;
    localparam int ROWIDX_W   = 5;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REGIDX_W   = 3;

    typedef logic [ROW_BITS_W-1:0] row_bits_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [COLOR_W-1:0]    color_t;
    typedef logic [GWIDTH_W-1:0]   gwidth_t;
    typedef logic [ROWIDX_W-1:0]   row_idx_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [REGIDX_W-1:0] REG_TEXT_COLOR    = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_BACK_COLOR    = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_GLYPH_WIDTH   = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

    localparam color_t  TEXT_COLOR_RST    = 16'd2016;
    localparam color_t  BACK_COLOR_RST    = 16'd0;
    localparam gwidth_t GLYPH_WIDTH_RST   = 5'd11;
    localparam coord_t  SCREEN_WIDTH_RST  = 10'd240;
    localparam coord_t  SCREEN_HEIGHT_RST = 10'd320;

endpackage

// ----- hw/rtl/gpe_glyph_row_if.sv -----
// Valid/ready channel carrying one packed glyph row word.
// Depends on gpe_pkg.
`timescale 1ns / 1ps

interface gpe_glyph_row_if
    import gpe_pkg::*;
;
    logic      valid;
    logic      ready;
    row_bits_t row_bits;
    coord_t    glyph_x;
    coord_t    glyph_y;
    row_idx_t  row_index;

    modport source (output valid, row_bits, glyph_x, glyph_y, row_index, input ready);
    modport sink   (input valid, row_bits, glyph_x, glyph_y, row_index, output ready);
endinterface

// ----- hw/rtl/gpe_pixel_if.sv -----
// Valid/ready channel carrying one screen pixel word.
// Depends on gpe_pkg.
`timescale 1ns / 1ps

interface gpe_pixel_if
    import gpe_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ----- hw/rtl/glyph_row_pixel_expander_top.sv -----
// Glyph row pixel expander: turns packed font rows into colored screen pixels.
// Depends on gpe_pkg, gpe_glyph_row_if and gpe_pixel_if.
//
// Usage:
//   glyph_in  - one word per glyph row: packed bits (MSB first), glyph x/y,
//               row index. Accepted when valid and ready are both high.
//   pixel_out - one word per visible pixel, left to right; last_pixel marks
//               the final pixel of a row. Rows fully off screen, or a glyph
//               width of zero, produce no words at all.
//   APB port  - text_color, back_color, glyph_width, screen_width,
//               screen_height at byte addresses 0, 4, 8, 12, 16. pready is
//               tied high; write only while the block is idle.
// Timing: a row is clipped and aligned as it is accepted into the work
// register, which then passes one pixel per cycle to the output register
// while that register is free. A row has at most 24 visible pixels; one
// with none is consumed on acceptance and never occupies the work register.
// The next row is taken in the cycle its predecessor's last pixel moves to
// the output register, so rows stream with no gap.
// Reset: registers return to their defaults, both stages empty.
// Stall: a low pixel_out.ready holds the output register; the work register
// waits behind it and glyph_in.ready drops until the row is drained.
`timescale 1ns / 1ps

module glyph_row_pixel_expander_top
    import gpe_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gpe_glyph_row_if.sink        glyph_in,
    gpe_pixel_if.source          pixel_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam gwidth_t MAX_W = gwidth_t'(MAX_GLYPH_WIDTH);

    // Configuration registers
    color_t  text_color_reg;
    color_t  back_color_reg;
    gwidth_t glyph_width_reg;
    coord_t  screen_width_reg;
    coord_t  screen_height_reg;

    logic                cfg_wr;
    logic [REGIDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg    <= TEXT_COLOR_RST;
            back_color_reg    <= BACK_COLOR_RST;
            glyph_width_reg   <= GLYPH_WIDTH_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TEXT_COLOR:    text_color_reg    <= pwdata[COLOR_W-1:0];
                REG_BACK_COLOR:    back_color_reg    <= pwdata[COLOR_W-1:0];
                REG_GLYPH_WIDTH:   glyph_width_reg   <= pwdata[GWIDTH_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[COORD_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TEXT_COLOR:    prdata = PDATA_W'(text_color_reg);
            REG_BACK_COLOR:    prdata = PDATA_W'(back_color_reg);
            REG_GLYPH_WIDTH:   prdata = PDATA_W'(glyph_width_reg);
            REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height_reg);
            default:           prdata = '0;
        endcase
    end

    // Row setup: clip against the screen and left-align the row bits
    gwidth_t             width_sat;
    logic [COORD_W:0]    row_y_full;
    coord_t              avail;
    gwidth_t             keep_cnt;
    logic                row_visible;
    row_bits_t           aligned;

    always_comb
    begin
        width_sat  = (glyph_width_reg > MAX_W) ? MAX_W : glyph_width_reg;
        row_y_full = {1'b0, glyph_in.glyph_y} + (COORD_W+1)'(glyph_in.row_index);
        avail      = screen_width_reg - glyph_in.glyph_x;
        keep_cnt   = (COORD_W'(width_sat) > avail) ? gwidth_t'(avail) : width_sat;
        row_visible = (width_sat != '0)
                    && (row_y_full < {1'b0, screen_height_reg})
                    && (glyph_in.glyph_x < screen_width_reg);
        // column 0 sits at the top bit of the row's byte span
        if (width_sat <= gwidth_t'(8))
            aligned = {glyph_in.row_bits[7:0], 16'b0};
        else if (width_sat <= gwidth_t'(16))
            aligned = {glyph_in.row_bits[15:0], 8'b0};
        else
            aligned = glyph_in.row_bits;
    end

    // Work register: current row, one column out per cycle while the output register is free
    logic      busy_reg,  busy_next;
    row_bits_t bits_reg,  bits_next;
    coord_t    x_reg,     x_next;
    coord_t    y_reg,     y_next;
    gwidth_t   rem_reg,   rem_next;

    // Output register
    logic      ovalid_reg, ovalid_next;
    coord_t    ox_reg,     ox_next;
    coord_t    oy_reg,     oy_next;
    color_t    ocolor_reg, ocolor_next;
    logic      olast_reg,  olast_next;

    logic out_free;
    logic emit;
    logic row_done;
    logic accept;

    assign out_free        = ~ovalid_reg | pixel_out.ready;
    assign emit            = busy_reg & out_free;
    assign row_done        = emit & (rem_reg == '0);
    assign glyph_in.ready  = ~busy_reg | row_done;
    assign accept          = glyph_in.valid & glyph_in.ready;

    always_comb
    begin
        busy_next   = busy_reg;
        bits_next   = bits_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg & ~pixel_out.ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ocolor_next = ocolor_reg;
        olast_next  = olast_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            ox_next     = x_reg;
            oy_next     = y_reg;
            ocolor_next = bits_reg[ROW_BITS_W-1] ? text_color_reg : back_color_reg;
            olast_next  = (rem_reg == '0);
            bits_next   = {bits_reg[ROW_BITS_W-2:0], 1'b0};
            x_next      = x_reg + coord_t'(1);
            rem_next    = rem_reg - gwidth_t'(1);
            if (rem_reg == '0)
                busy_next = 1'b0;
        end

        if (accept)
        begin
            // invisible rows are consumed without occupying the work register
            busy_next = row_visible;
            bits_next = aligned;
            x_next    = glyph_in.glyph_x;
            y_next    = row_y_full[COORD_W-1:0];
            rem_next  = keep_cnt - gwidth_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg   <= bits_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rem_reg    <= rem_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ocolor_reg <= ocolor_next;
        olast_reg  <= olast_next;
    end

    assign pixel_out.valid       = ovalid_reg;
    assign pixel_out.pixel_x     = ox_reg;
    assign pixel_out.pixel_y     = oy_reg;
    assign pixel_out.pixel_color = ocolor_reg;
    assign pixel_out.last_pixel  = olast_reg;

endmodule

// ----- sim/gpe_pixel_checker.sv -----
// Pixel checker for the glyph row pixel expander: watches the row, pixel and APB ports,
// predicts the pixels of every accepted row and compares them in order.
// Depends on gpe_pkg, gpe_glyph_row_if and gpe_pixel_if.
`timescale 1ns / 1ps

module gpe_pixel_checker
    import gpe_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    gpe_glyph_row_if           glyph_mon,
    gpe_pixel_if               pixel_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 error_count,
    output int                 pixels_owed
);

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    color_t  text_color;
    color_t  back_color;
    gwidth_t glyph_width;
    coord_t  screen_width;
    coord_t  screen_height;

    pixel_t  owed_pixels[$];

    initial
    begin
        error_count = 0;
        pixels_owed = 0;
    end

    // Expand one row into the pixels it must produce, left to right.
    task automatic expand_row(input row_bits_t bits, input coord_t gx, input coord_t gy,
                              input row_idx_t ri);
        int     w;
        int     top_bit;
        int     row;
        int     col;
        int     j;
        int     kept;
        pixel_t pix;
        w = (glyph_width > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : int'(glyph_width);
        if (w == 0)
            return;
        top_bit = 8 * ((w + 7) / 8) - 1;
        row = int'(gy) + int'(ri);
        if (row >= int'(screen_height))
            return;
        kept = 0;
        for (j = 0; j < w; j++)
        begin
            col = int'(gx) + j;
            if (col < int'(screen_width))
            begin
                pix.x     = coord_t'(col);
                pix.y     = coord_t'(row);
                pix.color = bits[top_bit - j] ? text_color : back_color;
                pix.last  = 1'b0;
                owed_pixels.push_back(pix);
                kept++;
            end
        end
        if (kept > 0)
        begin
            pix = owed_pixels.pop_back();
            pix.last = 1'b1;
            owed_pixels.push_back(pix);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            text_color    <= TEXT_COLOR_RST;
            back_color    <= BACK_COLOR_RST;
            glyph_width   <= GLYPH_WIDTH_RST;
            screen_width  <= SCREEN_WIDTH_RST;
            screen_height <= SCREEN_HEIGHT_RST;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_TEXT_COLOR:    text_color    <= pwdata[COLOR_W-1:0];
                    REG_BACK_COLOR:    back_color    <= pwdata[COLOR_W-1:0];
                    REG_GLYPH_WIDTH:   glyph_width   <= pwdata[GWIDTH_W-1:0];
                    REG_SCREEN_WIDTH:  screen_width  <= pwdata[COORD_W-1:0];
                    REG_SCREEN_HEIGHT: screen_height <= pwdata[COORD_W-1:0];
                    default: ;
                endcase
            end

            if (glyph_mon.valid && glyph_mon.ready)
                expand_row(glyph_mon.row_bits, glyph_mon.glyph_x, glyph_mon.glyph_y,
                           glyph_mon.row_index);

            if (pixel_mon.valid && pixel_mon.ready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    $error("pixel word with none owed: x=%0d y=%0d",
                           pixel_mon.pixel_x, pixel_mon.pixel_y);
                    error_count++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (pixel_mon.pixel_x !== want.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.x, pixel_mon.pixel_x);
                        error_count++;
                    end
                    if (pixel_mon.pixel_y !== want.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.y, pixel_mon.pixel_y);
                        error_count++;
                    end
                    if (pixel_mon.pixel_color !== want.color)
                    begin
                        $error("pixel_color: expected %h, got %h",
                               want.color, pixel_mon.pixel_color);
                        error_count++;
                    end
                    if (pixel_mon.last_pixel !== want.last)
                    begin
                        $error("last_pixel: expected %0b, got %0b",
                               want.last, pixel_mon.last_pixel);
                        error_count++;
                    end
                end
            end
            pixels_owed = owed_pixels.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the glyph row pixel expander bench: clock, reset, APB setup, row stimulus
// and pixel back-pressure; the verdict comes from gpe_pixel_checker.
// Depends on gpe_pkg, both channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module testbench;
    import gpe_pkg::*;

    localparam int LIMIT          = 500000;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN          = 30;
    localparam int PHASES         = 9;
    localparam int ROWS_PER_PHASE = 40;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pixels_owed;
    int                 cycles;
    bit                 calm;
    bit                 hold_request;
    int                 cur_sw;
    int                 cur_sh;

    gpe_glyph_row_if glyph_in ();
    gpe_pixel_if     pixel_out ();

    glyph_row_pixel_expander_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .glyph_in  (glyph_in),
        .pixel_out (pixel_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    gpe_pixel_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_mon   (glyph_in),
        .pixel_mon   (pixel_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .error_count (fail_count),
        .pixels_owed (pixels_owed)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Pixel sink: random stall bursts, one long hold-off on request, none when calm.
    initial
    begin
        int gap;
        pixel_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                pixel_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                pixel_out.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 5);
                pixel_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                pixel_out.ready <= 1'b1;
            end
            else
                pixel_out.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_SCREEN_WIDTH)
            cur_sw = int'(value[COORD_W-1:0]);
        if (idx == REG_SCREEN_HEIGHT)
            cur_sh = int'(value[COORD_W-1:0]);
    endtask

    task automatic program_font(input color_t tc, input color_t bc, input gwidth_t gw,
                                input coord_t sw, input coord_t sh);
        write_reg(REG_TEXT_COLOR, PDATA_W'(tc));
        write_reg(REG_BACK_COLOR, PDATA_W'(bc));
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(gw));
        write_reg(REG_SCREEN_WIDTH, PDATA_W'(sw));
        write_reg(REG_SCREEN_HEIGHT, PDATA_W'(sh));
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_row(input row_bits_t bits, input coord_t gx, input coord_t gy,
                            input row_idx_t ri);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            glyph_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        glyph_in.valid     <= 1'b1;
        glyph_in.row_bits  <= bits;
        glyph_in.glyph_x   <= gx;
        glyph_in.glyph_y   <= gy;
        glyph_in.row_index <= ri;
        do @(posedge clk); while (!glyph_in.ready);
    endtask

    // Mostly rows placed on screen; one in five anywhere in the field ranges.
    task automatic random_row();
        row_bits_t bits;
        coord_t    gx;
        coord_t    gy;
        row_idx_t  ri;
        bits = row_bits_t'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            gx = coord_t'($urandom);
            gy = coord_t'($urandom);
            ri = row_idx_t'($urandom);
        end
        else
        begin
            gx = coord_t'($urandom_range(0, cur_sw));
            gy = coord_t'($urandom_range(0, (cur_sh > 0) ? cur_sh - 1 : 0));
            ri = row_idx_t'($urandom_range(0, 23));
        end
        send_row(bits, gx, gy, ri);
    endtask

    function automatic gwidth_t rand_width();
        if ($urandom_range(0, 4) == 0)
            return gwidth_t'($urandom_range(0, 31));
        return gwidth_t'($urandom_range(1, 24));
    endfunction

    function automatic coord_t rand_extent();
        case ($urandom_range(0, 7))
            0: return coord_t'(0);
            1: return coord_t'(1);
            2: return coord_t'(1023);
            default: return coord_t'($urandom_range(16, 1023));
        endcase
    endfunction

    // Hold the row input until every owed pixel is out, then let the block settle.
    task automatic wait_drained();
        glyph_in.valid <= 1'b0;
        do @(negedge clk); while (pixels_owed != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        glyph_in.valid     <= 1'b0;
        glyph_in.row_bits  <= '0;
        glyph_in.glyph_x   <= '0;
        glyph_in.glyph_y   <= '0;
        glyph_in.row_index <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        calm = 1'b0;
        hold_request = 1'b0;
        cur_sw = int'(SCREEN_WIDTH_RST);
        cur_sh = int'(SCREEN_HEIGHT_RST);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: 11 wide on 240x320
        send_row(24'hFFFFFF, 10'd0, 10'd0, 5'd0);
        send_row(24'hFF5555, 10'd100, 10'd50, 5'd3);
        send_row(24'h00F0F0, 10'd235, 10'd300, 5'd19);    // right edge clips, bottom row
        send_row(24'h00FFFF, 10'd20, 10'd300, 5'd20);     // just below the screen
        send_row(24'h00FFFF, 10'd1023, 10'd0, 5'd0);      // fully right of the screen
        wait_drained();

        program_font(16'hFFFF, 16'h0000, 5'd24, 10'd1023, 10'd1023);
        send_row(24'hFFFFFF, 10'd0, 10'd0, 5'd0);
        send_row(24'h000000, 10'd999, 10'd1000, 5'd22);
        send_row(24'hAAAAAA, 10'd1000, 10'd0, 5'd23);
        send_row(24'h555555, 10'd512, 10'd1023, 5'd0);
        send_row(24'h123456, 10'd0, 10'd0, 5'd31);
        wait_drained();

        write_reg(REG_GLYPH_WIDTH, PDATA_W'(0));
        send_row(24'hFFFFFF, 10'd0, 10'd0, 5'd0);         // zero width: nothing out
        wait_drained();
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(31));         // saturates to the maximum
        send_row(24'hF0F0F0, 10'd3, 10'd7, 5'd1);
        wait_drained();
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(1));
        send_row(24'hFFFF7F, 10'd5, 10'd5, 5'd0);
        send_row(24'h000080, 10'd6, 10'd5, 5'd0);
        wait_drained();
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(8));
        send_row(24'hFFFFA5, 10'd40, 10'd40, 5'd2);
        wait_drained();
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(9));
        send_row(24'hFFFF80, 10'd40, 10'd41, 5'd2);
        wait_drained();
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(16));
        send_row(24'hFF1234, 10'd1010, 10'd42, 5'd2);
        wait_drained();
        write_reg(REG_GLYPH_WIDTH, PDATA_W'(17));
        send_row(24'hABCDEF, 10'd60, 10'd43, 5'd2);
        wait_drained();
        write_reg(REG_SCREEN_WIDTH, PDATA_W'(0));         // zero-width screen
        send_row(24'hFFFFFF, 10'd0, 10'd0, 5'd0);
        wait_drained();
        write_reg(REG_SCREEN_WIDTH, PDATA_W'(1023));
        write_reg(REG_SCREEN_HEIGHT, PDATA_W'(0));        // zero-height screen
        send_row(24'hFFFFFF, 10'd0, 10'd0, 5'd0);
        wait_drained();
        program_font(16'h0000, 16'hFFFF, 5'd24, 10'd1023, 10'd1023);
        send_row(24'h0F0F0F, 10'd200, 10'd200, 5'd7);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_font(color_t'($urandom), color_t'($urandom), 5'd24,
                                10'd1023, 10'd1023);
                1: program_font(16'hFFFF, 16'h0000, 5'd1, 10'd1, 10'd1);
                2: program_font(color_t'($urandom), color_t'($urandom), 5'd11,
                                SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
                default: program_font(color_t'($urandom), color_t'($urandom), rand_width(),
                                      rand_extent(), rand_extent());
            endcase
            if (phase == PHASES - 1)
                calm = 1'b1;
            for (n = 0; n < ROWS_PER_PHASE; n++)
                random_row();
            if (phase == 0)
            begin
                // sink stalls long while rows keep coming, so the input backs up
                wait_drained();
                hold_request = 1'b1;
                for (n = 0; n < 12; n++)
                    send_row(row_bits_t'($urandom), coord_t'($urandom_range(0, 900)),
                             coord_t'($urandom_range(0, 900)), row_idx_t'($urandom_range(0, 23)));
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
